// ===== src/afd_pkg.sv =====
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types, codes and helpers of the addressable LED frame driver.
// ----------------------------------------------------------------------------
package afd_pkg;

  localparam int MAX_LEDS_DEF = 1024;

  localparam int OP_W       = 2;
  localparam int IDX_W      = 10;
  localparam int COL_W      = 8;
  localparam int CNT_W      = 11;
  localparam int BIT_W      = 15;
  localparam int LAT_W      = 16;
  localparam int TICK_W     = 16;
  localparam int WORD_W     = 24;
  localparam int POS_W      = 5;
  localparam int STAT_W     = 2;
  localparam int LED_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [POS_W-1:0] POS_TOP = 5'd23;

  typedef enum logic [OP_W-1:0] {
    OP_SET     = 2'd0,
    OP_REFRESH = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BUSY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH      = 3'd5;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_HIGH  = 4'b0010,
    PH_LOW   = 4'b0100,
    PH_LATCH = 4'b1000
  } phase_t;

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_RUN   = 5'b00010,
    S_CLEAR = 5'b00100,
    S_FETCH = 5'b01000,
    S_LOAD  = 5'b10000
  } state_t;

  typedef struct packed {
    logic accept;
    logic init_sweep;
    logic clear_sweep;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic need_load;
    logic start_clear;
  } sts_t;

  function automatic logic [TICK_W-1:0] at_least_one(input logic [BIT_W-1:0] t);
    logic [TICK_W-1:0] r;
    r = (t == '0) ? TICK_W'(1) : TICK_W'(t);
    return r;
  endfunction

endpackage

// ===== src/afd_ifs.sv =====
// ----------------------------------------------------------------------------
// afd_ifs
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface afd_in_if;
  logic                        valid;
  logic                        ready;
  logic [afd_pkg::OP_W-1:0]    operation;
  logic [afd_pkg::IDX_W-1:0]   pixel_index;
  logic [afd_pkg::COL_W-1:0]   red;
  logic [afd_pkg::COL_W-1:0]   green;
  logic [afd_pkg::COL_W-1:0]   blue;

  modport source (output valid, operation, pixel_index, red, green, blue, input ready);
  modport sink   (input valid, operation, pixel_index, red, green, blue, output ready);
endinterface

interface afd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        line_level;
  logic                        busy_res;
  logic [afd_pkg::STAT_W-1:0]  status;

  modport source (output valid, line_level, busy_res, status, input ready);
  modport sink   (input valid, line_level, busy_res, status, output ready);
endinterface

// ===== src/afd_ctrl.sv =====
// ----------------------------------------------------------------------------
// afd_ctrl
// Controller: store clearing after reset, item handshake, clear sweep and
// pixel fetch sequencing.
// ----------------------------------------------------------------------------
module afd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  afd_pkg::sts_t sts,
  output afd_pkg::cmd_t cmd
);

  afd_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  assign in_ready  = (state_r == afd_pkg::S_RUN) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.accept      = accept;
    cmd.init_sweep  = (state_r == afd_pkg::S_INIT);
    cmd.clear_sweep = (state_r == afd_pkg::S_CLEAR);
    cmd.load        = (state_r == afd_pkg::S_LOAD);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      afd_pkg::S_INIT: begin
        if (sts.sweep_last) state_nxt = afd_pkg::S_RUN;
      end
      afd_pkg::S_RUN: begin
        if (accept && sts.need_load) begin
          state_nxt = sts.start_clear ? afd_pkg::S_CLEAR : afd_pkg::S_FETCH;
        end
      end
      afd_pkg::S_CLEAR: begin
        if (sts.sweep_last) state_nxt = afd_pkg::S_FETCH;
      end
      afd_pkg::S_FETCH: state_nxt = afd_pkg::S_LOAD;
      afd_pkg::S_LOAD:  state_nxt = afd_pkg::S_RUN;
      default:          state_nxt = afd_pkg::S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= afd_pkg::S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/afd_datapath.sv =====
// ----------------------------------------------------------------------------
// afd_datapath
// Pixel store, configuration registers, bit/phase sequencing and the result
// register.
// ----------------------------------------------------------------------------
module afd_datapath #(
  parameter int MAX_LEDS = afd_pkg::MAX_LEDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  afd_pkg::cmd_t                     cmd,
  output afd_pkg::sts_t                     sts,
  input  logic [afd_pkg::OP_W-1:0]          operation,
  input  logic [afd_pkg::IDX_W-1:0]         pixel_index,
  input  logic [afd_pkg::COL_W-1:0]         red,
  input  logic [afd_pkg::COL_W-1:0]         green,
  input  logic [afd_pkg::COL_W-1:0]         blue,
  input  logic                              cfg_we,
  input  logic [afd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [afd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              line_level,
  output logic                              busy_res,
  output logic [afd_pkg::STAT_W-1:0]        status
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  logic [afd_pkg::WORD_W-1:0] mem [MAX_LEDS];
  logic [afd_pkg::WORD_W-1:0] rd_data_r;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [afd_pkg::WORD_W-1:0] wr_data;

  logic [afd_pkg::CNT_W-1:0]  strip_len_r, strip_len_nxt;
  logic [afd_pkg::BIT_W-1:0]  zero_high_r, zero_high_nxt;
  logic [afd_pkg::BIT_W-1:0]  zero_low_r, zero_low_nxt;
  logic [afd_pkg::BIT_W-1:0]  one_high_r, one_high_nxt;
  logic [afd_pkg::BIT_W-1:0]  one_low_r, one_low_nxt;
  logic [afd_pkg::LAT_W-1:0]  latch_r, latch_nxt;

  afd_pkg::phase_t            phase_r, phase_nxt;
  logic [afd_pkg::LED_W-1:0]  cur_led_r, cur_led_nxt;
  logic [afd_pkg::POS_W-1:0]  bit_pos_r, bit_pos_nxt;
  logic [afd_pkg::TICK_W-1:0] ticks_r, ticks_nxt;
  logic [afd_pkg::WORD_W-1:0] shift_r, shift_nxt;
  logic [AW-1:0]              sweep_r, sweep_nxt;

  logic                       line_r, busy_r;
  logic [afd_pkg::STAT_W-1:0] status_r;

  logic [afd_pkg::CNT_W-1:0]  eff;
  logic                       busy;
  logic [afd_pkg::TICK_W-1:0] ticks_dec;
  logic                       cur_bit, next_bit;
  logic [afd_pkg::CNT_W-1:0]  next_led;
  logic                       res_line;
  logic [afd_pkg::STAT_W-1:0] res_status;
  afd_pkg::phase_t            latch_phase;
  logic [afd_pkg::TICK_W-1:0] latch_ticks;
  logic                       sweep_last;
  logic                       need_load;
  logic                       start_clear;

  assign eff       = (32'(strip_len_r) > MAX_LEDS) ? afd_pkg::CNT_W'(MAX_LEDS) : strip_len_r;
  assign busy      = (phase_r != afd_pkg::PH_IDLE);
  assign ticks_dec = (ticks_r != '0) ? ticks_r - 1'b1 : ticks_r;
  assign cur_bit   = shift_r[bit_pos_r];
  assign next_bit  = shift_r[bit_pos_r - 1'b1];
  assign next_led  = {1'b0, cur_led_r} + 1'b1;

  assign latch_phase = (latch_r == '0) ? afd_pkg::PH_IDLE : afd_pkg::PH_LATCH;
  assign latch_ticks = latch_r;

  assign sweep_last = cmd.init_sweep ? (32'(sweep_r) == MAX_LEDS - 1)
                                     : (32'(sweep_r) + 1 == 32'(eff));

  always_comb begin
    sts.sweep_last  = sweep_last;
    sts.need_load   = need_load;
    sts.start_clear = start_clear;
  end

  always_comb begin
    strip_len_nxt = strip_len_r;
    zero_high_nxt = zero_high_r;
    zero_low_nxt  = zero_low_r;
    one_high_nxt  = one_high_r;
    one_low_nxt   = one_low_r;
    latch_nxt     = latch_r;
    if (cfg_we) begin
      unique case (cfg_index)
        afd_pkg::CFG_STRIP_LEN: strip_len_nxt = cfg_data[afd_pkg::CNT_W-1:0];
        afd_pkg::CFG_ZERO_HIGH: zero_high_nxt = cfg_data[afd_pkg::BIT_W-1:0];
        afd_pkg::CFG_ZERO_LOW:  zero_low_nxt  = cfg_data[afd_pkg::BIT_W-1:0];
        afd_pkg::CFG_ONE_HIGH:  one_high_nxt  = cfg_data[afd_pkg::BIT_W-1:0];
        afd_pkg::CFG_ONE_LOW:   one_low_nxt   = cfg_data[afd_pkg::BIT_W-1:0];
        afd_pkg::CFG_LATCH:     latch_nxt     = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    cur_led_nxt = cur_led_r;
    bit_pos_nxt = bit_pos_r;
    ticks_nxt   = ticks_r;
    shift_nxt   = shift_r;
    sweep_nxt   = sweep_r;
    wr_en       = 1'b0;
    wr_addr     = sweep_r;
    wr_data     = '0;
    need_load   = 1'b0;
    start_clear = 1'b0;
    res_status  = afd_pkg::ST_OK;

    if (cmd.init_sweep || cmd.clear_sweep) begin
      wr_en     = 1'b1;
      sweep_nxt = sweep_last ? '0 : sweep_r + 1'b1;
    end

    if (cmd.load) begin
      shift_nxt   = rd_data_r;
      bit_pos_nxt = afd_pkg::POS_TOP;
      ticks_nxt   = afd_pkg::at_least_one(rd_data_r[afd_pkg::WORD_W-1] ? one_high_r
                                                                         : zero_high_r);
    end

    if (cmd.accept) begin
      unique case (afd_pkg::op_t'(operation))
        afd_pkg::OP_TICK: begin
          if (busy) begin
            ticks_nxt = ticks_dec;
            if (ticks_dec == '0) begin
              unique case (phase_r)
                afd_pkg::PH_HIGH: begin
                  phase_nxt = afd_pkg::PH_LOW;
                  ticks_nxt = afd_pkg::at_least_one(cur_bit ? one_low_r : zero_low_r);
                end
                afd_pkg::PH_LOW: begin
                  if (bit_pos_r != '0) begin
                    bit_pos_nxt = bit_pos_r - 1'b1;
                    phase_nxt   = afd_pkg::PH_HIGH;
                    ticks_nxt   = afd_pkg::at_least_one(next_bit ? one_high_r : zero_high_r);
                  end else if (next_led < eff) begin
                    cur_led_nxt = next_led[afd_pkg::LED_W-1:0];
                    phase_nxt   = afd_pkg::PH_HIGH;
                    need_load   = 1'b1;
                  end else begin
                    phase_nxt = latch_phase;
                    ticks_nxt = latch_ticks;
                  end
                end
                default: begin
                  phase_nxt = afd_pkg::PH_IDLE;
                  ticks_nxt = '0;
                end
              endcase
            end
          end
        end
        afd_pkg::OP_SET: begin
          if (busy) begin
            res_status = afd_pkg::ST_BUSY;
          end else if ({1'b0, pixel_index} >= eff) begin
            res_status = afd_pkg::ST_RANGE;
          end else begin
            wr_en   = 1'b1;
            wr_addr = AW'(pixel_index);
            wr_data = {green, red, blue};
          end
        end
        afd_pkg::OP_REFRESH, afd_pkg::OP_CLEAR: begin
          if (busy) begin
            res_status = afd_pkg::ST_BUSY;
          end else if (eff == '0) begin
            cur_led_nxt = '0;
            bit_pos_nxt = '0;
            phase_nxt   = latch_phase;
            ticks_nxt   = latch_ticks;
          end else begin
            cur_led_nxt = '0;
            phase_nxt   = afd_pkg::PH_HIGH;
            need_load   = 1'b1;
            start_clear = (afd_pkg::op_t'(operation) == afd_pkg::OP_CLEAR);
          end
        end
        default: ;
      endcase
    end

    if (afd_pkg::op_t'(operation) == afd_pkg::OP_TICK) begin
      res_line = (phase_r == afd_pkg::PH_HIGH);
    end else begin
      res_line = (phase_nxt == afd_pkg::PH_HIGH);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[AW'(cur_led_r)];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      line_r   <= res_line;
      busy_r   <= (afd_pkg::op_t'(operation) == afd_pkg::OP_TICK) ? busy
                                                                   : (phase_nxt != afd_pkg::PH_IDLE);
      status_r <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_len_r <= '0;
      zero_high_r <= afd_pkg::BIT_W'(14);
      zero_low_r  <= afd_pkg::BIT_W'(32);
      one_high_r  <= afd_pkg::BIT_W'(28);
      one_low_r   <= afd_pkg::BIT_W'(24);
      latch_r     <= afd_pkg::LAT_W'(3200);
      phase_r     <= afd_pkg::PH_IDLE;
      cur_led_r   <= '0;
      bit_pos_r   <= '0;
      ticks_r     <= '0;
      shift_r     <= '0;
      sweep_r     <= '0;
    end else begin
      strip_len_r <= strip_len_nxt;
      zero_high_r <= zero_high_nxt;
      zero_low_r  <= zero_low_nxt;
      one_high_r  <= one_high_nxt;
      one_low_r   <= one_low_nxt;
      latch_r     <= latch_nxt;
      phase_r     <= phase_nxt;
      cur_led_r   <= cur_led_nxt;
      bit_pos_r   <= bit_pos_nxt;
      ticks_r     <= ticks_nxt;
      shift_r     <= shift_nxt;
      sweep_r     <= sweep_nxt;
    end
  end

  assign line_level = line_r;
  assign busy_res   = busy_r;
  assign status     = status_r;

endmodule

// ===== src/addressable_led_frame_driver.sv =====
// ----------------------------------------------------------------------------
// addressable_led_frame_driver
// One-wire serial LED frame encoder with a pixel store and tick-paced output.
// ----------------------------------------------------------------------------
// Result: each result is registered in the cycle after its item is taken.
// Throughput: one item per cycle when not stalled; an item that starts a new
//   LED adds S_FETCH and S_LOAD for the pixel store read, and clear first
//   zeroes the LEDs in use. Reset: configuration returns to defaults and the
//   whole pixel store is cleared, during which no item is taken.
// ----------------------------------------------------------------------------
module addressable_led_frame_driver #(
  parameter int MAX_LEDS = afd_pkg::MAX_LEDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  afd_in_if.sink                         in_chan,
  afd_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [afd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afd_pkg::CFG_DATA_W-1:0] cfg_data
);

  afd_pkg::cmd_t cmd;
  afd_pkg::sts_t sts;

  afd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  afd_datapath #(
    .MAX_LEDS (MAX_LEDS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .operation   (in_chan.operation),
    .pixel_index (in_chan.pixel_index),
    .red         (in_chan.red),
    .green       (in_chan.green),
    .blue        (in_chan.blue),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .line_level  (out_chan.line_level),
    .busy_res    (out_chan.busy_res),
    .status      (out_chan.status)
  );

endmodule

// ===== src/afd_checker.sv =====
// ----------------------------------------------------------------------------
// afd_checker
// Port-level checks of the LED frame driver, bound to the top level.
// ----------------------------------------------------------------------------
module afd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic line_level,
  input logic busy_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(line_level) && $stable(busy_res))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("item taken before store clearing");

  a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy_res |-> !line_level)
    else $error("line high while idle");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while result stalled");

endmodule

bind addressable_led_frame_driver afd_checker u_afd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .line_level (out_chan.line_level),
  .busy_res   (out_chan.busy_res)
);

// ===== verif/afd_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afd_frame_checker
// Follows the pixel store, frame position and line phase of the LED frame
// driver from every command and tick item it takes. Each result item is
// compared field by field with the predicted line level, busy flag and status.
// ----------------------------------------------------------------------------
module afd_frame_checker
  import afd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  afd_in_if                     cmd_mon,
  afd_out_if                    line_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic              line;
    logic              busy;
    logic [STAT_W-1:0] status;
  } line_result_t;

  line_result_t expected_lines[$];

  logic [WORD_W-1:0] pixels [MAX_LEDS_DEF];
  phase_t            phase;
  logic [LED_W-1:0]  led;
  logic [POS_W-1:0]  bit_pos;
  logic [TICK_W-1:0] ticks_left;
  logic [WORD_W-1:0] shifter;

  logic [CNT_W-1:0]  strip_len;
  logic [BIT_W-1:0]  zero_high;
  logic [BIT_W-1:0]  zero_low;
  logic [BIT_W-1:0]  one_high;
  logic [BIT_W-1:0]  one_low;
  logic [LAT_W-1:0]  latch_len;

  function automatic logic [CNT_W-1:0] leds_in_use();
    return (strip_len > CNT_W'(MAX_LEDS_DEF)) ? CNT_W'(MAX_LEDS_DEF) : strip_len;
  endfunction

  function automatic logic [TICK_W-1:0] hold_len(input logic [BIT_W-1:0] t);
    return {1'b0, t} | TICK_W'(t == '0);
  endfunction

  function automatic void start_high();
    phase = PH_HIGH;
    ticks_left = hold_len(shifter[bit_pos] ? one_high : zero_high);
  endfunction

  function automatic void start_latch();
    if (latch_len == '0) begin
      phase = PH_IDLE;
      ticks_left = '0;
    end else begin
      phase = PH_LATCH;
      ticks_left = latch_len;
    end
  endfunction

  function automatic void load_led(input logic [CNT_W-1:0] n);
    led = n[LED_W-1:0];
    shifter = pixels[n[LED_W-1:0]];
    bit_pos = POS_TOP;
    start_high();
  endfunction

  function automatic void advance_phase();
    logic [CNT_W-1:0] nxt;
    nxt = {1'b0, led} + 1'b1;
    case (phase)
      PH_HIGH: begin
        phase = PH_LOW;
        ticks_left = hold_len(shifter[bit_pos] ? one_low : zero_low);
      end
      PH_LOW: begin
        if (bit_pos != '0) begin
          bit_pos = bit_pos - 1'b1;
          start_high();
        end else if (nxt < leds_in_use()) begin
          load_led(nxt);
        end else begin
          start_latch();
        end
      end
      default: begin
        phase = PH_IDLE;
        ticks_left = '0;
      end
    endcase
  endfunction

  function automatic line_result_t predict_line(input logic [OP_W-1:0] op_bits,
                                                input logic [IDX_W-1:0] idx,
                                                input logic [COL_W-1:0] r,
                                                input logic [COL_W-1:0] g,
                                                input logic [COL_W-1:0] b);
    line_result_t res;
    logic         was_busy;
    op_t          op;
    op = op_t'(op_bits);
    was_busy = (phase != PH_IDLE);
    res.status = ST_OK;
    if (op == OP_TICK) begin
      res.line = (phase == PH_HIGH);
      res.busy = was_busy;
      if (was_busy) begin
        if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
        if (ticks_left == '0) advance_phase();
      end
    end else begin
      if (was_busy) begin
        res.status = ST_BUSY;
      end else if (op == OP_SET) begin
        if ({1'b0, idx} >= leds_in_use()) res.status = ST_RANGE;
        else pixels[idx] = {g, r, b};
      end else begin
        if (op == OP_CLEAR) begin
          for (int n = 0; n < int'(leds_in_use()); n++) pixels[n] = '0;
        end
        if (leds_in_use() == '0) begin
          led = '0;
          bit_pos = '0;
          start_latch();
        end else begin
          load_led('0);
        end
      end
      res.line = (phase == PH_HIGH);
      res.busy = (phase != PH_IDLE);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    line_result_t got;
    line_result_t want;
    if (!rst_n) begin
      for (int n = 0; n < MAX_LEDS_DEF; n++) pixels[n] = '0;
      phase = PH_IDLE;
      led = '0;
      bit_pos = '0;
      ticks_left = '0;
      shifter = '0;
      strip_len = CNT_W'(0);
      zero_high = BIT_W'(14);
      zero_low = BIT_W'(32);
      one_high = BIT_W'(28);
      one_low = BIT_W'(24);
      latch_len = LAT_W'(3200);
      expected_lines.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STRIP_LEN: strip_len = cfg_data[CNT_W-1:0];
          CFG_ZERO_HIGH: zero_high = cfg_data[BIT_W-1:0];
          CFG_ZERO_LOW:  zero_low = cfg_data[BIT_W-1:0];
          CFG_ONE_HIGH:  one_high = cfg_data[BIT_W-1:0];
          CFG_ONE_LOW:   one_low = cfg_data[BIT_W-1:0];
          CFG_LATCH:     latch_len = cfg_data[LAT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        expected_lines.push_back(predict_line(cmd_mon.operation, cmd_mon.pixel_index,
                                              cmd_mon.red, cmd_mon.green, cmd_mon.blue));
      end
      if (line_mon.valid && line_mon.ready) begin
        got.line = line_mon.line_level;
        got.busy = line_mon.busy_res;
        got.status = line_mon.status;
        if (expected_lines.size() == 0) begin
          mismatches++;
          if (mismatches <= 100) begin
            $display("%0t: unexpected line result, got line %0b busy %0b status %0d",
                     $time, got.line, got.busy, got.status);
          end
        end else begin
          want = expected_lines.pop_front();
          if (got.line !== want.line || got.busy !== want.busy ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 100) begin
              $display({"%0t: line result mismatch, expected line %0b busy %0b status %0d,",
                        " got line %0b busy %0b status %0d"},
                       $time, want.line, want.busy, want.status,
                       got.line, got.busy, got.status);
            end
          end
        end
      end
    end
    outstanding <= expected_lines.size();
  end

endmodule

// ===== verif/addressable_led_frame_driver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressable_led_frame_driver_tb
// Drives set-pixel, refresh, clear and tick items into the LED frame driver
// in bursts while the result side stalls on its own pattern. Directed frames
// cover range and busy rejects, zero-length bits and latch, count saturation
// and oversized timing writes; random frames between them change the settings.
// ----------------------------------------------------------------------------
module addressable_led_frame_driver_tb;
  import afd_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT  = 5_000_000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  afd_in_if  cmd_bus ();
  afd_out_if line_bus ();

  int frame_errors;
  int frame_leftover;
  int cycle_count = 0;
  int sent_count  = 0;
  int res_count   = 0;
  int idle_mark   = 0;
  int burst_left  = 0;
  int stall_mode  = 0;
  int mode_left   = 0;
  int leds_in_use = 0;
  int frames      = 0;
  int settings    = 0;

  addressable_led_frame_driver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (cmd_bus),
    .out_chan  (line_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  afd_frame_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_mon     (cmd_bus),
    .line_mon    (line_bus),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (frame_errors),
    .outstanding (frame_leftover)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("addressable_led_frame_driver_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && line_bus.valid && line_bus.ready) begin
      res_count <= res_count + 1;
      if (!line_bus.busy_res) idle_mark <= res_count + 1;
    end
  end

  // hold ready according to the current stall mode
  initial begin
    line_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 400);
      end
      mode_left--;
      case (stall_mode)
        0: line_bus.ready <= 1'b1;
        1: line_bus.ready <= ($urandom_range(0, 3) != 0);
        2: line_bus.ready <= ($urandom_range(0, 3) == 0);
        default: line_bus.ready <= ((mode_left % 8) < 5);
      endcase
    end
  end

  task automatic push_item(input op_t op, input logic [IDX_W-1:0] idx,
                           input logic [COL_W-1:0] r, input logic [COL_W-1:0] g,
                           input logic [COL_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        cmd_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 32);
    end
    burst_left--;
    cmd_bus.valid <= 1'b1;
    cmd_bus.operation <= op;
    cmd_bus.pixel_index <= idx;
    cmd_bus.red <= r;
    cmd_bus.green <= g;
    cmd_bus.blue <= b;
    do @(posedge clk); while (!cmd_bus.ready);
    sent_count++;
  endtask

  task automatic push_random(input op_t op);
    push_item(op, IDX_W'($urandom), COL_W'($urandom), COL_W'($urandom), COL_W'($urandom));
  endtask

  // drop valid and wait for every result
  task automatic wait_results();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk); while (res_count != sent_count);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] cnt, input logic [15:0] zh,
                                input logic [15:0] zl, input logic [15:0] oh,
                                input logic [15:0] ol, input logic [15:0] lat);
    wait_results();
    repeat (4) @(posedge clk);
    write_reg(CFG_STRIP_LEN, cnt);
    write_reg(CFG_ZERO_HIGH, zh);
    write_reg(CFG_ZERO_LOW, zl);
    write_reg(CFG_ONE_HIGH, oh);
    write_reg(CFG_ONE_LOW, ol);
    write_reg(CFG_LATCH, lat);
    cfg_we <= 1'b0;
    leds_in_use = (int'(cnt[CNT_W-1:0]) > MAX_LEDS_DEF) ? MAX_LEDS_DEF
                                                        : int'(cnt[CNT_W-1:0]);
    settings++;
  endtask

  // tick, with occasional other items, until a result after the last command shows the line idle
  task automatic run_to_idle();
    int mark;
    do begin
      mark = sent_count;
      while (idle_mark < mark) begin
        if ($urandom_range(0, 31) == 0) push_random(op_t'($urandom_range(0, 2)));
        else push_random(OP_TICK);
      end
      wait_results();
    end while (idle_mark != sent_count);
  endtask

  task automatic start_frame(input op_t op);
    push_random(op);
    frames++;
    run_to_idle();
  endtask

  task automatic random_sequence();
    int nset;
    nset = $urandom_range(0, 5);
    repeat (nset) begin
      if (leds_in_use > 0 && $urandom_range(0, 3) != 0) begin
        push_item(OP_SET, IDX_W'($urandom_range(0, leds_in_use - 1)),
                  COL_W'($urandom), COL_W'($urandom), COL_W'($urandom));
      end else begin
        push_random(OP_SET);
      end
    end
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) push_random(OP_TICK);
    if ($urandom_range(0, 9) != 0) begin
      start_frame(($urandom_range(0, 2) == 0) ? OP_CLEAR : OP_REFRESH);
    end
  endtask

  initial begin
    int          rand_start;
    logic [15:0] cnt_pick;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.operation = '0;
    cmd_bus.pixel_index = '0;
    cmd_bus.red = '0;
    cmd_bus.green = '0;
    cmd_bus.blue = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // shorten the latch so the first frame stays brief
    write_reg(CFG_LATCH, 16'd40);
    cfg_we <= 1'b0;

    push_item(OP_SET, '0, 8'hFF, 8'hFF, 8'hFF);
    push_item(OP_SET, 10'h3FF, 8'h00, 8'h00, 8'h00);
    push_random(OP_TICK);
    push_random(OP_REFRESH);
    frames++;
    push_random(OP_SET);
    push_random(OP_REFRESH);
    push_random(OP_CLEAR);
    run_to_idle();

    apply_settings(16'd3, 16'd1, 16'd2, 16'd2, 16'd1, 16'd4);
    push_item(OP_SET, 10'd0, 8'hFF, 8'h00, 8'hA5);
    push_item(OP_SET, 10'd1, 8'h00, 8'hFF, 8'h5A);
    push_item(OP_SET, 10'd2, 8'h3C, 8'hC3, 8'h81);
    push_item(OP_SET, 10'd3, 8'h11, 8'h22, 8'h33);
    push_item(OP_SET, 10'h200, 8'h44, 8'h55, 8'h66);
    push_random(OP_TICK);
    start_frame(OP_REFRESH);
    start_frame(OP_CLEAR);
    start_frame(OP_REFRESH);

    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    push_random(OP_REFRESH);
    frames++;
    push_random(OP_SET);
    run_to_idle();
    apply_settings(16'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    push_item(OP_SET, 10'd0, 8'hFF, 8'hFF, 8'hFF);
    push_item(OP_SET, 10'd1, 8'h01, 8'h80, 8'h7E);
    start_frame(OP_REFRESH);

    rand_start = sent_count;
    while (sent_count - rand_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: cnt_pick = 16'd0;
        1: cnt_pick = 16'($urandom_range(4, 8));
        default: cnt_pick = 16'($urandom_range(1, 2));
      endcase
      apply_settings(cnt_pick, 16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                     16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                     16'($urandom_range(0, 6)));
      repeat (3) random_sequence();
    end

    apply_settings(16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2);
    push_item(OP_SET, 10'h3FF, 8'hA5, 8'h5A, 8'hFF);
    repeat (20) push_random(OP_SET);

    apply_settings(16'd0, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'd120);
    start_frame(OP_REFRESH);

    wait_results();
    repeat (8) @(posedge clk);
    $display("summary: %0d items and %0d results over %0d register settings, %0d frames",
             sent_count, res_count, settings, frames);
    $display("summary: range and busy rejects, zero-length bits and latch, saturated count");
    $display("summary: and oversized timing writes were exercised");
    if (frame_errors == 0 && frame_leftover == 0) begin
      $display("addressable_led_frame_driver_tb: clean");
    end else begin
      $display("addressable_led_frame_driver_tb: errors");
    end
    $finish;
  end

endmodule

// ===== addressable_led_frame_driver.f =====
src/afd_pkg.sv
src/afd_ifs.sv
src/afd_ctrl.sv
src/afd_datapath.sv
src/addressable_led_frame_driver.sv
src/afd_checker.sv
verif/afd_frame_checker.sv
verif/addressable_led_frame_driver_tb.sv
